[hdl/c2p_pkg.sv]
// c2p_pkg: shared types, widths and the arctangent table of the rectangular-to-polar block
// used by every module under hdl; depends on nothing

package c2p_pkg;

    localparam int DATA_WIDTH         = 16;
    localparam int ITERATIONS_DEFAULT = 16;
    localparam int ATAN_ENTRIES       = 24;
    localparam int GUARD_BITS         = 38 - DATA_WIDTH;
    localparam int PATH_WIDTH         = DATA_WIDTH + GUARD_BITS + 3;
    localparam int ACC_WIDTH          = 32;
    localparam int GAIN_WIDTH         = 24;
    localparam int MAG_SHIFT          = GUARD_BITS + GAIN_WIDTH;
    localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 24'd10188014;
    localparam logic [ACC_WIDTH-1:0]  HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x_coord;
        logic signed [DATA_WIDTH-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic        [DATA_WIDTH-1:0] magnitude;
        logic signed [DATA_WIDTH-1:0] angle;
    } polar_t;

    typedef struct packed {
        logic signed [PATH_WIDTH-1:0] x;
        logic signed [PATH_WIDTH-1:0] y;
        logic        [ACC_WIDTH-1:0]  acc;
        logic                         origin;
    } cordic_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ACC_WIDTH-1:0] atan_step(input int unsigned idx);
        logic [ACC_WIDTH-1:0] val;
        begin
            case (idx)
                0:       val = 32'h2000_0000;
                1:       val = 32'h12E4_051E;
                2:       val = 32'h09FB_385B;
                3:       val = 32'h0511_11D4;
                4:       val = 32'h028B_0D43;
                5:       val = 32'h0145_D7E1;
                6:       val = 32'h00A2_F61E;
                7:       val = 32'h0051_7C55;
                8:       val = 32'h0028_BE53;
                9:       val = 32'h0014_5F2F;
                10:      val = 32'h000A_2F98;
                11:      val = 32'h0005_17CC;
                12:      val = 32'h0002_8BE6;
                13:      val = 32'h0001_45F3;
                14:      val = 32'h0000_A2FA;
                15:      val = 32'h0000_517D;
                16:      val = 32'h0000_28BE;
                17:      val = 32'h0000_145F;
                18:      val = 32'h0000_0A30;
                19:      val = 32'h0000_0518;
                20:      val = 32'h0000_028C;
                21:      val = 32'h0000_0146;
                22:      val = 32'h0000_00A3;
                23:      val = 32'h0000_0051;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

[hdl/c2p_stage.sv]
// c2p_stage: one registered CORDIC vectoring micro-rotation
// depends on c2p_pkg

module c2p_stage #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             up_valid,
    input  c2p_pkg::cordic_t up_data,
    output logic             dn_valid,
    output c2p_pkg::cordic_t dn_data
);

    localparam int PW = c2p_pkg::PATH_WIDTH;
    localparam logic [c2p_pkg::ACC_WIDTH-1:0] STEP = c2p_pkg::atan_step(IDX);

    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] dy;
    logic                 valid_reg;
    c2p_pkg::cordic_t     data_reg;
    c2p_pkg::cordic_t     data_next;

    assign dx = $signed(up_data.y) >>> IDX;
    assign dy = $signed(up_data.x) >>> IDX;

    always_comb
    begin
        data_next = up_data;
        // zero y counts as nonnegative
        if (!up_data.y[PW-1])
        begin
            data_next.x   = up_data.x + dx;
            data_next.y   = up_data.y - dy;
            data_next.acc = up_data.acc + STEP;
        end
        else
        begin
            data_next.x   = up_data.x - dx;
            data_next.y   = up_data.y + dy;
            data_next.acc = up_data.acc - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[hdl/c2p_scale.sv]
// c2p_scale: gain compensation, rounding and saturation of the magnitude, angle rounding
// three register stages; depends on c2p_pkg

module c2p_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             up_valid,
    input  c2p_pkg::cordic_t up_data,
    output logic             dn_valid,
    output c2p_pkg::polar_t  dn_data
);

    localparam int PW     = c2p_pkg::PATH_WIDTH;
    localparam int DW     = c2p_pkg::DATA_WIDTH;
    localparam int AW     = c2p_pkg::ACC_WIDTH;
    localparam int GW     = c2p_pkg::GAIN_WIDTH;
    localparam int UW     = PW - 1;
    localparam int LO_W   = UW / 2;
    localparam int HI_W   = UW - LO_W;
    localparam int PROD_W = UW + GW;
    localparam int SHIFT  = c2p_pkg::MAG_SHIFT;
    localparam int TOP_W  = PROD_W - SHIFT;
    localparam logic [AW-1:0]     ANG_HALF = AW'(1) << (AW - DW - 1);
    localparam logic [PROD_W-1:0] MAG_HALF = PROD_W'(1) << (SHIFT - 1);

    logic [UW-1:0]        x_clamp;
    logic [AW-1:0]        ang_round;

    logic                 a_valid_reg;
    logic [LO_W+GW-1:0]   a_lo_reg;
    logic [HI_W+GW-1:0]   a_hi_reg;
    logic [DW-1:0]        a_angle_reg;

    logic                 b_valid_reg;
    logic [PROD_W-1:0]    b_sum_reg;
    logic [PROD_W-1:0]    b_sum_next;
    logic [DW-1:0]        b_angle_reg;

    logic                 c_valid_reg;
    logic [TOP_W-1:0]     mag_full;
    c2p_pkg::polar_t      c_data_reg;
    c2p_pkg::polar_t      c_data_next;

    assign x_clamp   = up_data.x[PW-1] ? '0 : up_data.x[UW-1:0];
    assign ang_round = up_data.acc + ANG_HALF;

    assign b_sum_next = (PROD_W'(a_hi_reg) << LO_W) + PROD_W'(a_lo_reg) + MAG_HALF;

    assign mag_full = b_sum_reg[PROD_W-1:SHIFT];

    always_comb
    begin
        c_data_next.angle = b_angle_reg;
        if (mag_full > TOP_W'({DW{1'b1}}))
        begin
            c_data_next.magnitude = '1;
        end
        else
        begin
            c_data_next.magnitude = mag_full[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= up_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // partial products of the gain multiply
            a_lo_reg    <= (LO_W+GW)'(x_clamp[LO_W-1:0]) * (LO_W+GW)'(c2p_pkg::INV_GAIN);
            a_hi_reg    <= (HI_W+GW)'(x_clamp[UW-1:LO_W]) * (HI_W+GW)'(c2p_pkg::INV_GAIN);
            a_angle_reg <= up_data.origin ? '0 : ang_round[AW-1:AW-DW];
            b_sum_reg   <= b_sum_next;
            b_angle_reg <= a_angle_reg;
            c_data_reg  <= c_data_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign dn_data  = c_data_reg;

endmodule

[hdl/cartesian_to_polar.sv]
// cartesian_to_polar: pipelined CORDIC rectangular-to-polar converter, top level
// depends on c2p_pkg, c2p_stage and c2p_scale
//
// Takes one point (signed x_coord, y_coord) per word and returns its rounded
// length and its four-quadrant binary angle, where 0x8000 is pi and -pi alike.
// The origin gives magnitude 0 and angle 0. The pipeline accepts a new word
// every clock unless the output stalls; a word passes one input register, one
// register per micro-rotation, and three for the split gain multiply, the
// rounding add and the output register. The whole pipeline holds while the
// output word waits, so point_ready follows polar_ready whenever an output
// word is pending.

module cartesian_to_polar #(
    parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_ready,
    input  c2p_pkg::point_t point,
    output logic            polar_valid,
    input  logic            polar_ready,
    output c2p_pkg::polar_t polar
);

    localparam int PW = c2p_pkg::PATH_WIDTH;

    logic             en;
    logic             in_valid_reg;
    c2p_pkg::cordic_t in_data_reg;
    c2p_pkg::cordic_t in_data_next;
    logic signed [PW-1:0] x_wide;
    logic signed [PW-1:0] y_wide;

    logic             chain_valid [ITERATIONS+1];
    c2p_pkg::cordic_t chain_data  [ITERATIONS+1];

    assign en          = !polar_valid || polar_ready;
    assign point_ready = en;

    assign x_wide = PW'($signed(point.x_coord));
    assign y_wide = PW'($signed(point.y_coord));

    // left half plane turned by a half turn first
    always_comb
    begin
        in_data_next.origin = (point.x_coord == '0) && (point.y_coord == '0);
        if (point.x_coord[c2p_pkg::DATA_WIDTH-1])
        begin
            in_data_next.x   = (-x_wide) <<< c2p_pkg::GUARD_BITS;
            in_data_next.y   = (-y_wide) <<< c2p_pkg::GUARD_BITS;
            in_data_next.acc = c2p_pkg::HALF_TURN;
        end
        else
        begin
            in_data_next.x   = x_wide <<< c2p_pkg::GUARD_BITS;
            in_data_next.y   = y_wide <<< c2p_pkg::GUARD_BITS;
            in_data_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= point_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_data_reg <= in_data_next;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_data[0]  = in_data_reg;

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_stage
        c2p_stage #(
            .IDX (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (chain_valid[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    c2p_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .up_valid (chain_valid[ITERATIONS]),
        .up_data  (chain_data[ITERATIONS]),
        .dn_valid (polar_valid),
        .dn_data  (polar)
    );

endmodule

[hdl/c2p_checker.sv]
// c2p_assertions: port-level assertions for cartesian_to_polar, bound to the top level
// depends on c2p_pkg

module c2p_assertions (
    input logic            clk,
    input logic            rst_n,
    input logic            point_valid,
    input logic            point_ready,
    input c2p_pkg::point_t point,
    input logic            polar_valid,
    input logic            polar_ready,
    input c2p_pkg::polar_t polar
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && !polar_ready |=> polar_valid && $stable(polar))
        else $error("output word changed while stalled");

    // input side only waits on a stalled output word
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !polar_valid || polar_ready |-> point_ready)
        else $error("input not ready without output stall");

    // zero length only comes from the origin, whose angle is zero
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        polar_valid && polar.magnitude == '0 |-> polar.angle == '0)
        else $error("zero magnitude with nonzero angle");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !polar_valid)
        else $error("output word right after reset");

endmodule

bind cartesian_to_polar c2p_assertions u_checker (.*);

[dv/c2p_checker.sv]
// c2p_checker: watches both channels of cartesian_to_polar, predicts each output word
// with its own CORDIC model and compares field by field; depends on c2p_pkg

module c2p_checker #(
    parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    input  logic            point_ready,
    input  c2p_pkg::point_t point,
    input  logic            polar_valid,
    input  logic            polar_ready,
    input  c2p_pkg::polar_t polar,
    output int              fails,
    output int              pending
);

    localparam longint unsigned FIELD_MAX = (64'd1 << c2p_pkg::DATA_WIDTH) - 1;

    // arctan(2^-i) in a 32-bit turn
    logic [31:0] arctan_q31 [0:23] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    c2p_pkg::polar_t due_polar[$];
    int              polars_out;

    function automatic c2p_pkg::polar_t to_polar(input c2p_pkg::point_t p);
        longint          re;
        longint          im;
        longint          re_step;
        longint          im_step;
        longint unsigned len;
        logic [31:0]     turn;
        c2p_pkg::polar_t r;
        re   = p.x_coord;
        im   = p.y_coord;
        turn = '0;
        r    = '0;
        if (re == 0 && im == 0)
            return r;
        // left half plane: rotate by a half turn first
        if (re < 0)
        begin
            re   = -re;
            im   = -im;
            turn = c2p_pkg::HALF_TURN;
        end
        re = re <<< c2p_pkg::GUARD_BITS;
        im = im <<< c2p_pkg::GUARD_BITS;
        for (int i = 0; i < ITERATIONS && i < c2p_pkg::ATAN_ENTRIES; i++)
        begin
            re_step = im >>> i;
            im_step = re >>> i;
            if (im >= 0)
            begin
                re   = re + re_step;
                im   = im - im_step;
                turn = turn + arctan_q31[i];
            end
            else
            begin
                re   = re - re_step;
                im   = im + im_step;
                turn = turn - arctan_q31[i];
            end
        end
        if (re < 0)
            re = 0;
        len = re;
        len = (len * c2p_pkg::INV_GAIN + (64'd1 << (c2p_pkg::GUARD_BITS + 23)))
              >> (c2p_pkg::GUARD_BITS + 24);
        if (len > FIELD_MAX)
            len = FIELD_MAX;
        turn        = turn + (32'd1 << (31 - c2p_pkg::DATA_WIDTH));
        r.magnitude = len[c2p_pkg::DATA_WIDTH-1:0];
        r.angle     = turn[31 -: c2p_pkg::DATA_WIDTH];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on output word %0d: %s is %0d, predicted %0d",
                 polars_out, what, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin
        c2p_pkg::polar_t want;
        if (!rst_n)
        begin
            due_polar.delete();
            fails      = 0;
            pending    = 0;
            polars_out = 0;
        end
        else
        begin
            if (polar_valid && polar_ready)
            begin
                if (due_polar.size() == 0)
                    report_mismatch("unexpected word, magnitude", polar.magnitude, -1);
                else
                begin
                    want = due_polar.pop_front();
                    if (polar.magnitude !== want.magnitude)
                        report_mismatch("magnitude", polar.magnitude, want.magnitude);
                    if (polar.angle !== want.angle)
                        report_mismatch("angle", polar.angle, want.angle);
                end
                polars_out++;
            end
            if (point_valid && point_ready)
                due_polar.push_back(to_polar(point));
            pending = due_polar.size();
        end
    end

endmodule

[dv/tb_cartesian_to_polar.sv]
// tb_cartesian_to_polar: drives points into cartesian_to_polar with random idling on both
// sides and gives the verdict; depends on c2p_pkg, c2p_checker and the block itself

module tb_cartesian_to_polar;

    localparam int ITERATIONS  = c2p_pkg::ITERATIONS_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1100;

    logic            clk;
    logic            rst_n;
    logic            point_valid;
    logic            point_ready;
    c2p_pkg::point_t point;
    logic            polar_valid;
    logic            polar_ready;
    c2p_pkg::polar_t polar;
    int              fails;
    int              pending;
    int              hold_cycles = 0;
    bit              steady = 1'b0;
    int              cycle_count;

    cartesian_to_polar #(
        .ITERATIONS (ITERATIONS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .polar_valid (polar_valid),
        .polar_ready (polar_ready),
        .polar       (polar)
    );

    c2p_checker #(
        .ITERATIONS (ITERATIONS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .polar_valid (polar_valid),
        .polar_ready (polar_ready),
        .polar       (polar),
        .fails       (fails),
        .pending     (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic c2p_pkg::point_t mk_point(input int x, input int y);
        c2p_pkg::point_t p;
        p.x_coord = 16'(x);
        p.y_coord = 16'(y);
        return p;
    endfunction

    function automatic c2p_pkg::point_t random_point();
        c2p_pkg::point_t p;
        int              a;
        int              picks[6] = '{-32768, -32767, -1, 0, 1, 32767};
        p.x_coord = 16'($urandom);
        p.y_coord = 16'($urandom);
        case ($urandom_range(0, 9))
            5:
            begin
                p.x_coord = 16'($urandom_range(0, 32) - 16);
                p.y_coord = 16'($urandom_range(0, 32) - 16);
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    p.x_coord = '0;
                else
                    p.y_coord = '0;
            end
            // close to the negative real axis, where pi wraps
            7:
            begin
                p.x_coord = 16'(-$urandom_range(1, 32768));
                p.y_coord = 16'($urandom_range(0, 6) - 3);
            end
            8:
            begin
                p.x_coord = 16'(picks[$urandom_range(0, 5)]);
                p.y_coord = 16'(picks[$urandom_range(0, 5)]);
            end
            9:
            begin
                a = $urandom_range(1, 32767);
                p.x_coord = 16'($urandom_range(0, 1) ? a : -a);
                p.y_coord = 16'($urandom_range(0, 1) ? a : -a);
            end
            default:
                ;
        endcase
        return p;
    endfunction

    task automatic send_point(input c2p_pkg::point_t p, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            point_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int xs[22] = '{0, 32767, -32768, 0, 0, 1, -1, 0, 0, 32767, -32768,
                       -32768, 32767, -32768, -32768, -1, -1, 1, -32767, 3, -30000, 12345};
        int ys[22] = '{0, 0, 0, 32767, -32768, 0, 0, 1, -1, 32767, -32768,
                       32767, -32768, 1, -1, 1, -1, -1, 32767, 4, -2, -23456};
        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 22; i++)
            send_point(mk_point(xs[i], ys[i]), pick_gap());
        // receiver stops for a long stretch so the pipeline backs up
        hold_cycles = 300;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            steady = (i >= 500 && i < 650);
            send_point(random_point(), pick_gap());
        end
        steady = 1'b0;
        @(negedge clk);
        point_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (ITERATIONS + 8) @(negedge clk);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int run_len;
        int stall;
        int n;
        polar_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
                @(negedge clk);
                polar_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            run_len = $urandom_range(1, 40);
            repeat (run_len)
            begin
                @(negedge clk);
                polar_ready <= 1'b1;
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                polar_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
